@@ src/ssplit_pkg.sv @@
// Shared types and constants for the SQL statement splitter.
`timescale 1ns / 1ps

package ssplit_pkg;

  // Character codes
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  // Result queue sizing
  localparam int PushMax   = 3;
  localparam int FifoDepth = 8;
  localparam int FifoAw    = $clog2(FifoDepth);

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       stmt_end;
    logic       last;
  } res_t;

  // Results produced by one input byte, in output order
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [PushMax-1:0]     ent;
  } push_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

endpackage

@@ src/ssplit_core.sv @@
// Input register, quote/whitespace state and per-byte result generation.
`timescale 1ns / 1ps

module ssplit_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_eoq_i,
  output ssplit_pkg::push_t    push_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eoq_q;

  logic inq_q, inq_d;
  logic dbl_q, dbl_d;
  logic esc_q, esc_d;
  logic sp_q, sp_d;
  logic has_q, has_d;

  logic [7:0]        mark;
  logic [1:0]        idx;
  ssplit_pkg::push_t push;

  // Capture the accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_eoq_q  <= in_eoq_i;
    end
  end

  // Parse one byte and list its results
  always_comb begin
    inq_d = inq_q;
    dbl_d = dbl_q;
    esc_d = esc_q;
    sp_d  = sp_q;
    has_d = has_q;
    push  = '0;
    idx   = 2'd0;
    mark  = dbl_q ? ssplit_pkg::ChDquote : ssplit_pkg::ChSquote;
    if (in_valid_q) begin
      if (inq_q) begin
        push.ent[idx] = '{data: in_byte_q, stmt_end: 1'b0, last: 1'b0};
        idx = idx + 2'd1;
        has_d = 1'b1;
        if (in_byte_q == ssplit_pkg::ChBslash) begin
          esc_d = !esc_q;
        end else begin
          if (!esc_q && (in_byte_q == mark)) begin
            inq_d = 1'b0;
          end
          esc_d = 1'b0;
        end
      end else if (ssplit_pkg::is_blank(in_byte_q)) begin
        if (has_q) begin
          sp_d = 1'b1;
        end
      end else if (in_byte_q == ssplit_pkg::ChSemi) begin
        sp_d = 1'b0;
        if (has_q) begin
          push.ent[idx] = '{data: 8'h00, stmt_end: 1'b1, last: 1'b0};
          idx = idx + 2'd1;
        end
        has_d = 1'b0;
      end else begin
        if (sp_q) begin
          push.ent[idx] = '{data: ssplit_pkg::ChSpace, stmt_end: 1'b0, last: 1'b0};
          idx = idx + 2'd1;
        end
        sp_d = 1'b0;
        push.ent[idx] = '{data: in_byte_q, stmt_end: 1'b0, last: 1'b0};
        idx = idx + 2'd1;
        has_d = 1'b1;
        if ((in_byte_q == ssplit_pkg::ChDquote) || (in_byte_q == ssplit_pkg::ChSquote)) begin
          inq_d = 1'b1;
          dbl_d = (in_byte_q == ssplit_pkg::ChDquote);
          esc_d = 1'b0;
        end
      end
      // Close the open statement at end of query and clear all state
      if (in_eoq_q) begin
        if (has_d) begin
          push.ent[idx] = '{data: 8'h00, stmt_end: 1'b1, last: 1'b0};
          idx = idx + 2'd1;
        end
        inq_d = 1'b0;
        dbl_d = 1'b0;
        esc_d = 1'b0;
        sp_d  = 1'b0;
        has_d = 1'b0;
      end
      push.cnt = idx;
      if (idx != 2'd0) begin
        push.ent[idx - 2'd1].last = 1'b1;
      end
    end
  end

  assign push_o = push;

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_q <= 1'b0;
      dbl_q <= 1'b0;
      esc_q <= 1'b0;
      sp_q  <= 1'b0;
      has_q <= 1'b0;
    end else begin
      inq_q <= inq_d;
      dbl_q <= dbl_d;
      esc_q <= esc_d;
      sp_q  <= sp_d;
      has_q <= has_d;
    end
  end

  // End of query leaves the parser in its reset state
  a_eoq_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_eoq_q) |=> (!inq_q && !esc_q && !sp_q && !has_q))
    else $error("state not cleared after end of query");

  // A pending space only exists inside a non-empty statement, outside quotes
  a_space_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q |-> (has_q && !inq_q))
    else $error("pending space outside a statement");

endmodule

@@ src/ssplit_fifo.sv @@
// Result queue: takes up to three results per cycle, hands out one per transfer.
`timescale 1ns / 1ps

module ssplit_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssplit_pkg::push_t             push_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output ssplit_pkg::res_t              head_o,
  output logic [ssplit_pkg::FifoAw:0]   level_o
);

  ssplit_pkg::res_t mem_q [ssplit_pkg::FifoDepth];

  logic [ssplit_pkg::FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [ssplit_pkg::FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [ssplit_pkg::FifoAw:0]   level_q, level_d;
  logic                          pop;

  assign pop = pop_i && (level_q != '0);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + ssplit_pkg::FifoAw'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + ssplit_pkg::FifoAw'(pop);
    level_d  = level_q + (ssplit_pkg::FifoAw + 1)'(push_i.cnt)
               - (ssplit_pkg::FifoAw + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Write the new results at consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ssplit_pkg::PushMax; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[wr_ptr_q + ssplit_pkg::FifoAw'(i)] <= push_i.ent[i];
      end
    end
  end

  assign valid_o = (level_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

  // The queue never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q + (ssplit_pkg::FifoAw + 1)'(push_i.cnt)) <= (ssplit_pkg::FifoDepth + pop))
    else $error("result queue overflow");

  // Pointer distance matches the fill level
  a_ptr_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q != (ssplit_pkg::FifoAw + 1)'(ssplit_pkg::FifoDepth)) |->
      (ssplit_pkg::FifoAw'(wr_ptr_q - rd_ptr_q) == level_q[ssplit_pkg::FifoAw-1:0]))
    else $error("queue pointers disagree with level");

endmodule

@@ src/sql_statement_splitter.sv @@
// Top level of the SQL statement splitter.
`timescale 1ns / 1ps

// Splits a byte stream of query text into statements at unquoted ';'. Each
// input transfer carries one byte (tlast marks the final byte of the query)
// and causes zero to three output transfers: cleaned bytes (tuser = 0) and
// end-of-statement marks (tuser = 1, tdata = 0); tlast flags the final output
// of each input byte. The block accepts one byte per cycle while tready is
// high; a byte reaches the output through an input register, the parser
// logic and an eight-entry result queue. Input tready drops only when that
// queue, which absorbs the extra space and end-mark results, could not take
// three more results beyond those of the byte already in the input register.
module sql_statement_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_query
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] statement_end
  output logic       m_axis_tlast    // last_of_run
);

  ssplit_pkg::push_t           push;
  ssplit_pkg::res_t            head;
  logic [ssplit_pkg::FifoAw:0] level;
  logic [ssplit_pkg::FifoAw:0] committed;

  // Reserve room for the item in flight plus one more
  assign committed     = level + (ssplit_pkg::FifoAw + 1)'(push.cnt);
  assign s_axis_tready = committed <=
                         (ssplit_pkg::FifoAw + 1)'(ssplit_pkg::FifoDepth - ssplit_pkg::PushMax);

  ssplit_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid && s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eoq_i   (s_axis_tlast),
    .push_o     (push)
  );

  ssplit_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .level_o (level)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tuser = head.stmt_end;
  assign m_axis_tlast = head.last;

endmodule
